>>> hdl/stsg_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and arithmetic helpers of the stereo test signal generator.
package stsg_pkg;

  localparam int SAMPLE_BITS        = 16;
  localparam int INC_BITS           = 23;
  localparam int NOISE_BITS         = 32;
  localparam int GAIN_BITS          = 17;
  localparam int GAIN_FRAC          = 15;
  localparam int GAIN_ROUND         = 1 << (GAIN_FRAC - 1);
  localparam int PROD_BITS          = SAMPLE_BITS + GAIN_BITS;
  localparam int CFG_INDEX_BITS     = 3;
  localparam int PHASE_BITS_DEF     = 24;
  localparam int SINE_ADDR_BITS_DEF = 10;

  localparam logic [NOISE_BITS-1:0] NOISE_SEED  = 32'h6d2b79f5;
  localparam longint unsigned       HALF_PI_Q30 = 64'd1686629713;

  // Register indexes of the configuration port
  localparam logic [CFG_INDEX_BITS-1:0] REG_AUDITION_ENABLE = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SIGNAL_MODE     = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_INC_A_MAIN      = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_INC_A_SQUARE    = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_INC_B_MAIN      = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_INC_B_NOISE     = 3'd5;

  localparam logic [1:0] MODE_SINE   = 2'd0;
  localparam logic [1:0] MODE_SQUARE = 2'd1;
  localparam logic [1:0] MODE_NOISE  = 2'd2;

  localparam logic [INC_BITS-1:0] INC_A_MAIN_RST   = 23'd41848;
  localparam logic [INC_BITS-1:0] INC_A_SQUARE_RST = 23'd27772;
  localparam logic [INC_BITS-1:0] INC_B_MAIN_RST   = 23'd68859;
  localparam logic [INC_BITS-1:0] INC_B_NOISE_RST  = 23'd111468;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [SAMPLE_BITS+1:0] wide_t;
  typedef logic signed [GAIN_BITS-1:0]   gain_t;

  // Q2.15 gains
  localparam gain_t G_036  = 17'sd11796;
  localparam gain_t G_082  = 17'sd26870;
  localparam gain_t G_025  = 17'sd8192;
  localparam gain_t G_018  = 17'sd5898;
  localparam gain_t G_032  = 17'sd10486;
  localparam gain_t G_028  = 17'sd9175;
  localparam gain_t G_070N = -17'sd22938;
  localparam gain_t G_040  = 17'sd13107;

  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef struct packed {
    sample_t in_left;
    sample_t in_right;
  } in_item_t;

  typedef struct packed {
    sample_t out_left;
    sample_t out_right;
  } out_item_t;

  // Gain product rounded half up: floor((x*g + 2^14) / 2^15)
  function automatic sample_t mulq(input sample_t x, input gain_t g);
    logic signed [PROD_BITS-1:0] p;
    p = PROD_BITS'(x) * PROD_BITS'(g) + PROD_BITS'(GAIN_ROUND);
    return p[GAIN_FRAC +: SAMPLE_BITS];
  endfunction

  function automatic sample_t sat(input wide_t v);
    sample_t r;
    if (v > wide_t'(SAMPLE_MAX)) begin
      r = SAMPLE_MAX;
    end else if (v < wide_t'(SAMPLE_MIN)) begin
      r = SAMPLE_MIN;
    end else begin
      r = v[SAMPLE_BITS-1:0];
    end
    return r;
  endfunction

  // Elaboration-time helpers for constant levels and the sine table
  localparam longint FULL_SCALE = longint'(1) << (SAMPLE_BITS - 1);

  function automatic longint mulq_c(input longint x, input longint g);
    return (x * g + longint'(GAIN_ROUND)) >>> GAIN_FRAC;
  endfunction

  function automatic longint sat_c(input longint v);
    longint r;
    r = v;
    if (v > FULL_SCALE - 1) r = FULL_SCALE - 1;
    if (v < -FULL_SCALE) r = -FULL_SCALE;
    return r;
  endfunction

  // Quarter-wave sine at position r of 2^qbits, Taylor series to x^15 in Q30
  function automatic longint quarter_sine(input longint r, input int qbits);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    longint          amp;
    longint          v;
    x    = (longint'(r) * HALF_PI_Q30) >> qbits;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    amp  = FULL_SCALE - 1;
    for (int n = 1; n <= 7; n++) begin
      term = (term * x2) >> 30;
      case (n)
        1: term = term / 6;
        2: term = term / 20;
        3: term = term / 42;
        4: term = term / 72;
        5: term = term / 110;
        6: term = term / 156;
        default: term = term / 210;
      endcase
      if (n % 2 == 1) sum = sum - longint'(term);
      else            sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    v = (sum * amp + (longint'(1) << 29)) >>> 30;
    return (v > amp) ? amp : v;
  endfunction

  localparam longint SQ_LEVEL = mulq_c(FULL_SCALE, longint'(G_036));

  localparam sample_t SQUARE_LEFT_POS  = sample_t'(sat_c(SQ_LEVEL));
  localparam sample_t SQUARE_LEFT_NEG  = sample_t'(sat_c(-SQ_LEVEL));
  localparam sample_t SQUARE_RIGHT_POS = sample_t'(sat_c(-mulq_c(SQ_LEVEL, longint'(G_082))));
  localparam sample_t SQUARE_RIGHT_NEG = sample_t'(sat_c(-mulq_c(-SQ_LEVEL, longint'(G_082))));

endpackage

>>> hdl/stsg_sine_rom.sv
`timescale 1ns / 1ps
// Quarter-wave sine table with registered read and sign restore.
module stsg_sine_rom import stsg_pkg::*; #(
  parameter int PHASE_BITS = PHASE_BITS_DEF,
  parameter int ADDR_BITS  = SINE_ADDR_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [PHASE_BITS-1:0] phase,
  output sample_t               sine
);

  localparam int QUARTER_BITS = ADDR_BITS - 2;
  localparam int QUARTER      = 1 << QUARTER_BITS;
  localparam int QIDX_BITS    = ADDR_BITS - 1;

  typedef sample_t qrom_t [QUARTER+1];

  function automatic qrom_t build_qrom();
    qrom_t tbl;
    for (int i = 0; i <= QUARTER; i++) begin
      tbl[i] = sample_t'(quarter_sine(longint'(i), QUARTER_BITS));
    end
    return tbl;
  endfunction

  localparam qrom_t SINE_QUARTER = build_qrom();

  logic [ADDR_BITS-1:0] addr;
  logic [QIDX_BITS-1:0] roff;
  logic [QIDX_BITS-1:0] ridx;
  sample_t              mag;
  logic                 neg;

  assign addr = phase[PHASE_BITS-1 -: ADDR_BITS];
  assign roff = QIDX_BITS'(addr[QUARTER_BITS-1:0]);
  // Second and fourth quarters run the table backward
  assign ridx = addr[QUARTER_BITS] ? QIDX_BITS'(QUARTER) - roff : roff;

  always_ff @(posedge clk) begin
    if (en) begin
      mag <= SINE_QUARTER[ridx];
      neg <= addr[ADDR_BITS-1];
    end
  end

  assign sine = neg ? -mag : mag;

endmodule

>>> hdl/stereo_test_signal_generator_top.sv
`timescale 1ns / 1ps
// Stereo test signal generator: passes a sample pair through or replaces it by a
// dual sine, a square or a noise-plus-tone pair from two phase accumulators.
// One pair is accepted every clock cycle while smp_stall is low; each pair passes
// through the phase register, the registered sine table read, the first gain stage
// and the output register. A stall at the output holds the pipeline only once every
// stage is full; empty stages keep taking input.
// Configuration writes are always ready and take effect on the next accepted pair.
module stereo_test_signal_generator_top import stsg_pkg::*; #(
  parameter int PHASE_BITS     = PHASE_BITS_DEF,
  parameter int SINE_ADDR_BITS = SINE_ADDR_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      smp_valid,
  output logic                      smp_stall,
  input  in_item_t                  smp,
  output logic                      res_valid,
  input  logic                      res_stall,
  output out_item_t                 res,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [INC_BITS-1:0]       cfg_data
);

  // Configuration registers
  logic                audition_enable;
  logic [1:0]          signal_mode;
  logic [INC_BITS-1:0] inc_a_main;
  logic [INC_BITS-1:0] inc_a_square;
  logic [INC_BITS-1:0] inc_b_main;
  logic [INC_BITS-1:0] inc_b_noise;

  // Generator state
  logic [PHASE_BITS-1:0] phase_a;
  logic [PHASE_BITS-1:0] phase_b;
  logic [NOISE_BITS-1:0] noise_state;
  logic [PHASE_BITS-1:0] phase_a_next;
  logic [PHASE_BITS-1:0] phase_b_next;
  logic [NOISE_BITS-1:0] noise_next;
  logic [NOISE_BITS-1:0] ns1;
  logic [NOISE_BITS-1:0] ns2;
  logic [NOISE_BITS-1:0] ns3;
  logic [1:0]            mode_eff;
  logic                  accept;

  // Pipeline
  logic      s1_valid, s2_valid, s3_valid;
  logic      s1_load, s2_load, s3_load, s4_load;
  logic      s1_en, s2_en, s3_en;
  logic [1:0] s1_mode, s2_mode, s3_mode;
  in_item_t  s1_pair, s2_pair, s3_pair;
  sample_t   s1_noise, s2_noise;
  logic      s1_sq_neg, s2_sq_neg, s3_sq_neg;
  sample_t   sine_a, sine_b;
  sample_t   x3, y3;
  sample_t   x3_next, y3_next;
  out_item_t res_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      audition_enable <= 1'b0;
      signal_mode     <= MODE_SINE;
      inc_a_main      <= INC_A_MAIN_RST;
      inc_a_square    <= INC_A_SQUARE_RST;
      inc_b_main      <= INC_B_MAIN_RST;
      inc_b_noise     <= INC_B_NOISE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_AUDITION_ENABLE: audition_enable <= cfg_data[0];
        REG_SIGNAL_MODE:     signal_mode     <= cfg_data[1:0];
        REG_INC_A_MAIN:      inc_a_main      <= cfg_data;
        REG_INC_A_SQUARE:    inc_a_square    <= cfg_data;
        REG_INC_B_MAIN:      inc_b_main      <= cfg_data;
        REG_INC_B_NOISE:     inc_b_noise     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Mode three behaves as noise plus tone
  assign mode_eff = signal_mode[1] ? MODE_NOISE : signal_mode;

  assign phase_a_next = phase_a +
    PHASE_BITS'((mode_eff == MODE_SQUARE) ? inc_a_square : inc_a_main);
  assign phase_b_next = phase_b +
    PHASE_BITS'((mode_eff == MODE_NOISE) ? inc_b_noise : inc_b_main);

  // xorshift32, reseeded when it falls to zero
  assign ns1        = noise_state ^ (noise_state << 13);
  assign ns2        = ns1 ^ (ns1 >> 17);
  assign ns3        = ns2 ^ (ns2 << 5);
  assign noise_next = (ns3 == '0) ? NOISE_SEED : ns3;

  // Advance a stage when the one after it is empty or moving
  assign s4_load   = !res_valid || !res_stall;
  assign s3_load   = !s3_valid || s4_load;
  assign s2_load   = !s2_valid || s3_load;
  assign s1_load   = !s1_valid || s2_load;
  assign smp_stall = !s1_load;
  assign accept    = smp_valid && s1_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_a     <= '0;
      phase_b     <= '0;
      noise_state <= NOISE_SEED;
    end else if (accept && audition_enable) begin
      phase_a <= phase_a_next;
      phase_b <= phase_b_next;
      if (mode_eff == MODE_NOISE) begin
        noise_state <= noise_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (s1_load) s1_valid  <= smp_valid;
      if (s2_load) s2_valid  <= s1_valid;
      if (s3_load) s3_valid  <= s2_valid;
      if (s4_load) res_valid <= s3_valid;
    end
  end

  // Stage 1: new phases sit in the state registers, the rest travels here
  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_en     <= audition_enable;
      s1_mode   <= mode_eff;
      s1_pair   <= smp;
      s1_noise  <= sample_t'({~noise_next[NOISE_BITS-1],
                              noise_next[NOISE_BITS-2 -: SAMPLE_BITS-1]});
      s1_sq_neg <= phase_a_next[PHASE_BITS-1];
    end
  end

  // Stage 2: sine table reads
  stsg_sine_rom #(
    .PHASE_BITS (PHASE_BITS),
    .ADDR_BITS  (SINE_ADDR_BITS)
  ) u_rom_a (
    .clk   (clk),
    .en    (s2_load),
    .phase (phase_a),
    .sine  (sine_a)
  );

  stsg_sine_rom #(
    .PHASE_BITS (PHASE_BITS),
    .ADDR_BITS  (SINE_ADDR_BITS)
  ) u_rom_b (
    .clk   (clk),
    .en    (s2_load),
    .phase (phase_b),
    .sine  (sine_b)
  );

  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_en     <= s1_en;
      s2_mode   <= s1_mode;
      s2_pair   <= s1_pair;
      s2_noise  <= s1_noise;
      s2_sq_neg <= s1_sq_neg;
    end
  end

  // Stage 3: first gain products
  always_comb begin
    if (s2_mode == MODE_NOISE) begin
      x3_next = mulq(s2_noise, G_025);
      y3_next = mulq(sine_b, G_018);
    end else begin
      x3_next = mulq(sine_a, G_032);
      y3_next = mulq(sine_b, G_028);
    end
  end

  always_ff @(posedge clk) begin
    if (s3_load) begin
      s3_en     <= s2_en;
      s3_mode   <= s2_mode;
      s3_pair   <= s2_pair;
      s3_sq_neg <= s2_sq_neg;
      x3        <= x3_next;
      y3        <= y3_next;
    end
  end

  // Stage 4: mix, saturate and select
  always_comb begin
    res_next.out_left  = s3_pair.in_left;
    res_next.out_right = s3_pair.in_right;
    if (s3_en) begin
      case (s3_mode)
        MODE_SINE: begin
          res_next.out_left  = x3;
          res_next.out_right = y3;
        end
        MODE_SQUARE: begin
          res_next.out_left  = s3_sq_neg ? SQUARE_LEFT_NEG : SQUARE_LEFT_POS;
          res_next.out_right = s3_sq_neg ? SQUARE_RIGHT_NEG : SQUARE_RIGHT_POS;
        end
        default: begin
          res_next.out_left  = sat(wide_t'(x3) + wide_t'(y3));
          res_next.out_right = sat(wide_t'(mulq(x3, G_070N)) + wide_t'(mulq(y3, G_040)));
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s4_load) begin
      res <= res_next;
    end
  end

`ifndef NO_ASSERTIONS
  // A pass-through transfer leaves the phases alone
  a_bypass_holds_phase: assert property (@(posedge clk) disable iff (rst)
    accept && !audition_enable |=> $stable(phase_a) && $stable(phase_b))
    else $error("phase moved on a pass-through transfer");

  // Noise advances only in noise mode with the generator on
  a_noise_only_in_mode: assert property (@(posedge clk) disable iff (rst)
    accept && !(audition_enable && signal_mode[1]) |=> $stable(noise_state))
    else $error("noise state moved outside noise mode");

  a_noise_nonzero: assert property (@(posedge clk) disable iff (rst)
    noise_state != '0)
    else $error("noise state reached zero");

  // An accepted pair always lands in the first stage
  a_accept_fills_s1: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted pair lost at stage one");
`endif

endmodule
